/* design/rdc_pkg.sv */
// Shared types and constants for the radix digit converter.
// Used by rdc_front, rdc_queue, rdc_back and radix_digit_converter_top.
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

    localparam int IN_DIGITS   = 10;
    localparam int NIB_W       = 4;
    localparam int DIG_W       = NIB_W * IN_DIGITS;
    localparam int VAL_W       = DIG_W;
    localparam int BASE_W      = 4;
    localparam int CMD_W       = 2;
    localparam int POS_W       = 6;
    localparam int MAX_RESULTS = 34;

    localparam int IDX_W  = (IN_DIGITS > 1) ? $clog2(IN_DIGITS) : 1;
    localparam int NDIG_W = $clog2(IN_DIGITS + 1);

    // Long division by the output base: DIV_BITS quotient bits per cycle
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = (VAL_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W     = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam int IN_TDATA_W  = ((DIG_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((BASE_W + POS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BASE_W;
    localparam logic [CFG_IDX_W-1:0] REG_IN_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_BASE = 1'b1;

    localparam logic [BASE_W-1:0] IN_BASE_RST  = 4'd10;
    localparam logic [BASE_W-1:0] OUT_BASE_RST = 4'd2;
    localparam logic [BASE_W-1:0] BASE_MIN     = 4'd2;
    localparam logic [BASE_W-1:0] BASE_MAX     = 4'd10;

    localparam logic [CMD_W-1:0] CMD_CONVERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRC     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RC      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DIG_W-1:0]  digits;
        logic              err;
        logic [NDIG_W-1:0] ndig;
        logic [BASE_W-1:0] b1;
        logic [BASE_W-1:0] b2;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

/* design/rdc_front.sv */
// Front end: base registers, input check and digit count, job push.
// Depends on rdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rdc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [rdc_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [rdc_pkg::DIG_W-1:0]     i_digits,
    input  wire rdc_pkg::t_q_stat              i_q_stat,
    output logic                               o_push,
    output rdc_pkg::t_job                      o_job
);

    logic [rdc_pkg::BASE_W-1:0] r_in_base;
    logic [rdc_pkg::BASE_W-1:0] r_out_base;
    logic [rdc_pkg::BASE_W-1:0] w_b1;
    logic [rdc_pkg::BASE_W-1:0] w_b2;
    logic                       w_bad;
    logic [rdc_pkg::NDIG_W-1:0] w_ndig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_base  <= rdc_pkg::IN_BASE_RST;
            r_out_base <= rdc_pkg::OUT_BASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rdc_pkg::REG_IN_BASE:  r_in_base  <= i_cfg_data;
                rdc_pkg::REG_OUT_BASE: r_out_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the stored bases into 2..10
    always_comb begin
        w_b1 = r_in_base;
        if (r_in_base < rdc_pkg::BASE_MIN) w_b1 = rdc_pkg::BASE_MIN;
        if (r_in_base > rdc_pkg::BASE_MAX) w_b1 = rdc_pkg::BASE_MAX;
        w_b2 = r_out_base;
        if (r_out_base < rdc_pkg::BASE_MIN) w_b2 = rdc_pkg::BASE_MIN;
        if (r_out_base > rdc_pkg::BASE_MAX) w_b2 = rdc_pkg::BASE_MAX;
    end

    // Flag any digit not below the input base; count up to the top nonzero digit
    always_comb begin
        w_bad  = 1'b0;
        w_ndig = rdc_pkg::NDIG_W'(1);
        for (int i = 0; i < rdc_pkg::IN_DIGITS; i++) begin
            if (i_digits[i*rdc_pkg::NIB_W +: rdc_pkg::NIB_W] >= w_b1) w_bad = 1'b1;
            if (i_digits[i*rdc_pkg::NIB_W +: rdc_pkg::NIB_W] != '0)
                w_ndig = rdc_pkg::NDIG_W'(i + 1);
        end
    end

    assign o_ready = !i_q_stat.full;
    // Drop unused commands here
    assign o_push  = i_valid && !i_q_stat.full && (i_cmd != rdc_pkg::CMD_NONE);

    always_comb begin
        o_job.cmd    = i_cmd;
        o_job.digits = i_digits;
        o_job.err    = w_bad;
        o_job.ndig   = w_ndig;
        o_job.b1     = w_b1;
        o_job.b2     = w_b2;
    end

endmodule

`default_nettype wire

/* design/rdc_queue.sv */
// Short job queue between the front end and the digit engine.
// Depends on rdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rdc_pkg::t_job i_job,
    input  wire logic          i_pop,
    output rdc_pkg::t_job      o_head,
    output rdc_pkg::t_q_stat   o_stat
);

    rdc_pkg::t_job               r_slot [rdc_pkg::QDEPTH];
    logic [rdc_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [rdc_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [rdc_pkg::QCNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == rdc_pkg::QPTR_W'(rdc_pkg::QDEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == rdc_pkg::QPTR_W'(rdc_pkg::QDEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    assign o_head       = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == rdc_pkg::QCNT_W'(rdc_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rdc_pkg::QCNT_W'(rdc_pkg::QDEPTH))
        else $error("job queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("job queue popped while empty");

endmodule

`default_nettype wire

/* design/rdc_back.sv */
// Digit engine: Horner accumulation, long division by the output base,
// digit-wise complements, and the output register. Depends on rdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdc_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rdc_pkg::t_job                i_head,
    input  wire rdc_pkg::t_q_stat             i_q_stat,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [rdc_pkg::BASE_W-1:0]        o_digit,
    output logic [rdc_pkg::POS_W-1:0]         o_pos,
    output logic                              o_last,
    output logic                              o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HORNER,
        S_DIV,
        S_COMP,
        S_EMIT
    } t_state;

    t_state                      r_state,   n_state;
    rdc_pkg::t_job               r_job,     n_job;
    logic [rdc_pkg::DIV_W-1:0]   r_val,     n_val;
    logic [rdc_pkg::BASE_W-1:0]  r_rem,     n_rem;
    logic [rdc_pkg::STEP_W-1:0]  r_step,    n_step;
    logic [rdc_pkg::IDX_W-1:0]   r_idx,     n_idx;
    logic [rdc_pkg::POS_W-1:0]   r_pos,     n_pos;
    logic                        r_carry,   n_carry;
    logic [rdc_pkg::BASE_W-1:0]  r_dig,     n_dig;
    logic                        r_last,    n_last;
    logic                        r_status,  n_status;
    logic                        r_out_valid,  n_out_valid;
    logic [rdc_pkg::BASE_W-1:0]  r_out_digit,  n_out_digit;
    logic [rdc_pkg::POS_W-1:0]   r_out_pos,    n_out_pos;
    logic                        r_out_last,   n_out_last;
    logic                        r_out_status, n_out_status;

    logic                                  w_slot;
    logic [rdc_pkg::NIB_W-1:0]             w_hdig;
    logic [rdc_pkg::NIB_W-1:0]             w_cdig;
    logic [rdc_pkg::VAL_W+rdc_pkg::BASE_W-1:0] w_mul;
    logic [rdc_pkg::DIV_BITS-1:0]          w_top;
    logic [rdc_pkg::DIV_BITS-1:0]          w_q;
    logic [rdc_pkg::BASE_W:0]              w_r;
    logic [rdc_pkg::DIV_W-1:0]             w_val_div;
    logic [rdc_pkg::BASE_W:0]              w_c;

    assign w_slot = !r_out_valid || i_ready;
    assign w_hdig = r_job.digits[{r_idx, 2'b00} +: rdc_pkg::NIB_W];
    assign w_cdig = r_job.digits[{r_pos[rdc_pkg::IDX_W-1:0], 2'b00} +: rdc_pkg::NIB_W];

    // One Horner step: value * in_base + next digit
    assign w_mul = (rdc_pkg::VAL_W + rdc_pkg::BASE_W)'(r_val[rdc_pkg::VAL_W-1:0])
                 * (rdc_pkg::VAL_W + rdc_pkg::BASE_W)'(r_job.b1)
                 + (rdc_pkg::VAL_W + rdc_pkg::BASE_W)'(w_hdig);

    // DIV_BITS restoring steps of division by out_base, top bits first
    always_comb begin
        w_top = r_val[rdc_pkg::DIV_W-1 -: rdc_pkg::DIV_BITS];
        w_r   = {1'b0, r_rem};
        w_q   = '0;
        for (int k = rdc_pkg::DIV_BITS - 1; k >= 0; k--) begin
            w_r = {w_r[rdc_pkg::BASE_W-1:0], w_top[k]};
            if (w_r >= {1'b0, r_job.b2}) begin
                w_r  = w_r - {1'b0, r_job.b2};
                w_q[k] = 1'b1;
            end
        end
        w_val_div = (r_val << rdc_pkg::DIV_BITS) | rdc_pkg::DIV_W'(w_q);
    end

    // One complement digit: (b1 - 1) - d + carry, wrapped into 0..b1-1
    always_comb begin
        w_c = {1'b0, r_job.b1} - 1'b1 - {1'b0, w_cdig} + {{rdc_pkg::BASE_W{1'b0}}, r_carry};
    end

    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_val        = r_val;
        n_rem        = r_rem;
        n_step       = r_step;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_carry      = r_carry;
        n_dig        = r_dig;
        n_last       = r_last;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_digit  = r_out_digit;
        n_out_pos    = r_out_pos;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        o_pop        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop    = 1'b1;
                    n_job    = i_head;
                    n_pos    = '0;
                    n_status = 1'b0;
                    if (i_head.err) begin
                        n_dig    = '0;
                        n_last   = 1'b1;
                        n_status = 1'b1;
                        n_state  = S_EMIT;
                    end else if (i_head.cmd == rdc_pkg::CMD_CONVERT) begin
                        n_val   = '0;
                        n_idx   = rdc_pkg::IDX_W'(i_head.ndig - 1'b1);
                        n_state = S_HORNER;
                    end else begin
                        n_carry = (i_head.cmd == rdc_pkg::CMD_RC);
                        n_state = S_COMP;
                    end
                end
            end
            S_HORNER: begin
                n_val = rdc_pkg::DIV_W'(w_mul[rdc_pkg::VAL_W-1:0]);
                if (r_idx == '0) begin
                    n_step  = '0;
                    n_rem   = '0;
                    n_state = S_DIV;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            S_DIV: begin
                n_val = w_val_div;
                n_rem = w_r[rdc_pkg::BASE_W-1:0];
                if (r_step == rdc_pkg::STEP_W'(rdc_pkg::DIV_STEPS - 1)) begin
                    n_dig   = w_r[rdc_pkg::BASE_W-1:0];
                    n_last  = (w_val_div == '0) ||
                              (r_pos == rdc_pkg::POS_W'(rdc_pkg::MAX_RESULTS - 1));
                    n_state = S_EMIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_COMP: begin
                if (w_c >= {1'b0, r_job.b1}) begin
                    n_dig   = rdc_pkg::BASE_W'(w_c - {1'b0, r_job.b1});
                    n_carry = 1'b1;
                end else begin
                    n_dig   = w_c[rdc_pkg::BASE_W-1:0];
                    n_carry = 1'b0;
                end
                n_last  = (r_pos == rdc_pkg::POS_W'(r_job.ndig - 1'b1));
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_out_valid  = 1'b1;
                    n_out_digit  = r_dig;
                    n_out_pos    = r_pos;
                    n_out_last   = r_last;
                    n_out_status = r_status;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos = r_pos + 1'b1;
                        if (r_job.cmd == rdc_pkg::CMD_CONVERT) begin
                            n_step  = '0;
                            n_rem   = '0;
                            n_state = S_DIV;
                        end else begin
                            n_state = S_COMP;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_job        <= n_job;
        r_val        <= n_val;
        r_rem        <= n_rem;
        r_step       <= n_step;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_carry      <= n_carry;
        r_dig        <= n_dig;
        r_last       <= n_last;
        r_status     <= n_status;
        r_out_digit  <= n_out_digit;
        r_out_pos    <= n_out_pos;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    assign o_valid  = r_out_valid;
    assign o_digit  = r_out_digit;
    assign o_pos    = r_out_pos;
    assign o_last   = r_out_last;
    assign o_status = r_out_status;

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> (r_out_last && (r_out_pos == '0)))
        else $error("error result is not a single digit at position zero");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_job.b2))
        else $error("division remainder not below output base");

    a_comp_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> ((r_job.cmd == rdc_pkg::CMD_DRC) ||
                                 (r_job.cmd == rdc_pkg::CMD_RC)))
        else $error("complement step on a non-complement job");

endmodule

`default_nettype wire

/* design/radix_digit_converter_top.sv */
// Radix digit converter top level: front end, job queue and digit engine.
// Depends on rdc_pkg, rdc_front, rdc_queue and rdc_back.
//
//  Channel    Direction  Carries
//  s_axis_*   in         tuser[1:0] command; tdata[39:0] packed BCD digits
//  m_axis_*   out        tdata[3:0] digit, [9:4] position; tlast; tuser status
//  i_cfg_*    in         index 0 in_base, index 1 out_base, 4-bit data
//
// Conversion of an n-digit input: Horner steps form the value, one input
// digit per step, then each output digit comes from long division through
// the 8-bit-per-cycle divider plus one emit. Complements alternate a
// complement step and an emit per digit; a bad digit gives one error result.
// The two-entry job queue takes new requests while the engine works.
// Reset is synchronous, active low; output stalls hold the engine in emit.
`timescale 1ns / 1ps
`default_nettype none

module radix_digit_converter_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rdc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rdc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [rdc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // digits
    input  wire logic [rdc_pkg::CMD_W-1:0]          s_axis_tuser,  // command
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [rdc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // digit, position
    output logic                                    m_axis_tuser,  // status
    output logic                                    m_axis_tlast
);

    rdc_pkg::t_job               w_push_job;
    rdc_pkg::t_job               w_head;
    rdc_pkg::t_q_stat            w_q_stat;
    logic                        w_push;
    logic                        w_pop;
    logic [rdc_pkg::BASE_W-1:0]  w_digit;
    logic [rdc_pkg::POS_W-1:0]   w_pos;

    rdc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_digits   (s_axis_tdata[rdc_pkg::DIG_W-1:0]),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    rdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    rdc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_digit  (w_digit),
        .o_pos    (w_pos),
        .o_last   (m_axis_tlast),
        .o_status (m_axis_tuser)
    );

    assign m_axis_tdata = rdc_pkg::OUT_TDATA_W'({w_pos, w_digit});

endmodule

`default_nettype wire
